// ===== src/uagp_pkg.sv =====
package uagp_pkg;

   localparam int unsigned REG_W = 13;
   localparam int unsigned FRAME_W = 32;
   localparam int unsigned COORD_W = 12;
   localparam int unsigned DEF_MAX_WIDTH = 4096;
   localparam int unsigned DEF_MAX_HEIGHT = 4096;
   localparam logic [REG_W-1:0] WIDTH_RESET = 13'd1920;
   localparam logic [REG_W-1:0] HEIGHT_RESET = 13'd1080;
   localparam logic [7:0] LUMA_LO = 8'd16;
   localparam logic [7:0] LUMA_SPAN = 8'd219;
   localparam logic [7:0] CHROMA_LO = 8'd64;
   localparam logic [7:0] CHROMA_SPAN = 8'd128;
   localparam logic CSR_WIDTH = 1'b0;
   localparam logic CSR_HEIGHT = 1'b1;

   typedef struct packed {
      logic [FRAME_W-1:0] frame_number;
      logic [COORD_W-1:0] pixel_x;
      logic [COORD_W-1:0] pixel_y;
   } req_type;

   typedef struct packed {
      logic [7:0] chroma_u;
      logic [7:0] luma_left;
      logic [7:0] chroma_v;
      logic [7:0] luma_right;
   } rsp_type;

endpackage

// ===== src/uyvy_animated_gradient_pattern.sv =====
// channel | direction | beat content
// req     | in        | frame_number, pixel_x, pixel_y
// rsp     | out       | chroma_u, luma_left, chroma_v, luma_right
// csr     | in        | index 0 frame_width, index 1 frame_height
// One beat per cycle enters whenever the output is not stalled.
// The phase moduli are bit-serial over the frame number, four bits per stage,
// and the coordinates are reduced alongside, two bits per stage.
// Reset restores 1920 by 1080 and empties the pipeline.
// A stalled output freezes every stage, so nothing is lost or repeated.
module uyvy_animated_gradient_pattern import uagp_pkg::*; #(
   parameter int unsigned MAX_WIDTH = DEF_MAX_WIDTH,
   parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_index,
   input  logic [REG_W-1:0] csr_data
);
   localparam int unsigned MS = 8;
   localparam int unsigned NS = MS + 5;
   localparam int unsigned CW = 2 * MS;
   localparam int unsigned MW_P = $clog2(MAX_WIDTH + MAX_HEIGHT + 1) + 1;
   localparam int unsigned MW = (MW_P > REG_W + 2) ? MW_P : REG_W + 2;

   logic [REG_W-1:0] width_ff, height_ff;
   logic [NS-1:0] vld_ff;
   logic          adv;
   logic [13:0]   w, h, wh;
   logic [FRAME_W-1:0] fr_ff [MS];
   logic [CW-1:0] ax0_ff [MS];
   logic [CW-1:0] ax1_ff [MS];
   logic [CW-1:0] ay_ff [MS];
   logic [CW-1:0] ac_ff [MS];
   logic [MW-1:0] rx_ff [MS+1];
   logic [MW-1:0] ry_ff [MS+1];
   logic [MW-1:0] rc_ff [MS+1];
   logic [MW-1:0] qx0_ff [MS+1];
   logic [MW-1:0] qx1_ff [MS+1];
   logic [MW-1:0] qy_ff [MS+1];
   logic [MW-1:0] qc_ff [MS+1];
   logic [MW-1:0] rx_in [MS], ry_in [MS], rc_in [MS];
   logic [MW-1:0] qx0_in [MS], qx1_in [MS], qy_in [MS], qc_in [MS];
   logic [MW-1:0] phx, phy, phc;
   logic [13:0] x0_ff, x1_ff, yy_ff, cc_ff;
   logic [7:0]  cu, yl, cv, yr;

   assign w = 14'(width_ff);
   assign h = 14'(height_ff);
   assign wh = 14'(width_ff) + 14'(height_ff);
   assign adv = !vld_ff[NS-1] || rsp_ready;
   assign req_ready = adv;
   assign csr_ready = 1'b1;
   assign rsp_valid = vld_ff[NS-1];
   assign rsp_data = '{chroma_u: cu, luma_left: yl, chroma_v: cv, luma_right: yr};

   function automatic logic [MW-1:0] mstep(logic [MW-1:0] r, logic b, logic [13:0] m);
      logic [MW:0] t;
      t = {r, b};
      if (m == 14'd0) return '0;
      if (t >= (MW+1)'(m)) t = t - (MW+1)'(m);
      return t[MW-1:0];
   endfunction

   function automatic logic [MW-1:0] madd(logic [MW:0] s, logic [13:0] m);
      logic [MW+1:0] t;
      t = (MW+2)'(s);
      if (m == 14'd0) return '0;
      if (t >= (MW+2)'(m)) t = t - (MW+2)'(m);
      if (t >= (MW+2)'(m)) t = t - (MW+2)'(m);
      return t[MW-1:0];
   endfunction

   always_comb begin
      for (int s = 0; s < MS; s++) begin
         rx_in[s] = rx_ff[s];
         ry_in[s] = ry_ff[s];
         rc_in[s] = rc_ff[s];
         qx0_in[s] = qx0_ff[s];
         qx1_in[s] = qx1_ff[s];
         qy_in[s] = qy_ff[s];
         qc_in[s] = qc_ff[s];
         for (int b = 3; b >= 0; b--) begin
            rx_in[s] = mstep(rx_in[s], fr_ff[s][FRAME_W-1-4*s-(3-b)], w);
            ry_in[s] = mstep(ry_in[s], fr_ff[s][FRAME_W-1-4*s-(3-b)], h);
            rc_in[s] = mstep(rc_in[s], fr_ff[s][FRAME_W-1-4*s-(3-b)], wh);
         end
         for (int b = 1; b >= 0; b--) begin
            qx0_in[s] = mstep(qx0_in[s], ax0_ff[s][CW-1-2*s-(1-b)], w);
            qx1_in[s] = mstep(qx1_in[s], ax1_ff[s][CW-1-2*s-(1-b)], w);
            qy_in[s] = mstep(qy_in[s], ay_ff[s][CW-1-2*s-(1-b)], h);
            qc_in[s] = mstep(qc_in[s], ac_ff[s][CW-1-2*s-(1-b)], wh);
         end
      end
   end

   // The frame remainders are scaled by 8, 5 and 3 through doubling steps.
   always_comb begin
      phx = mstep(mstep(mstep(rx_ff[MS], 1'b0, w), 1'b0, w), 1'b0, w);
      phy = madd((MW+1)'(mstep(mstep(ry_ff[MS], 1'b0, h), 1'b0, h)) +
                 (MW+1)'(ry_ff[MS]), h);
      phc = madd((MW+1)'(mstep(rc_ff[MS], 1'b0, wh)) + (MW+1)'(rc_ff[MS]), wh);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         vld_ff <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_WIDTH:  width_ff <= csr_data;
               CSR_HEIGHT: height_ff <= csr_data;
               default:    width_ff <= width_ff;
            endcase
         end
         if (adv) vld_ff <= {vld_ff[NS-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         fr_ff[0] <= req_data.frame_number;
         ax0_ff[0] <= CW'(req_data.pixel_x);
         ax1_ff[0] <= CW'(req_data.pixel_x) + CW'(1);
         ay_ff[0] <= CW'(req_data.pixel_y);
         ac_ff[0] <= CW'(req_data.pixel_x) + CW'(req_data.pixel_y);
         rx_ff[0] <= '0;
         ry_ff[0] <= '0;
         rc_ff[0] <= '0;
         qx0_ff[0] <= '0;
         qx1_ff[0] <= '0;
         qy_ff[0] <= '0;
         qc_ff[0] <= '0;
         for (int s = 0; s < MS - 1; s++) begin
            fr_ff[s+1] <= fr_ff[s];
            ax0_ff[s+1] <= ax0_ff[s];
            ax1_ff[s+1] <= ax1_ff[s];
            ay_ff[s+1] <= ay_ff[s];
            ac_ff[s+1] <= ac_ff[s];
         end
         for (int s = 0; s < MS; s++) begin
            rx_ff[s+1] <= rx_in[s];
            ry_ff[s+1] <= ry_in[s];
            rc_ff[s+1] <= rc_in[s];
            qx0_ff[s+1] <= qx0_in[s];
            qx1_ff[s+1] <= qx1_in[s];
            qy_ff[s+1] <= qy_in[s];
            qc_ff[s+1] <= qc_in[s];
         end
         // Stage after the reduction: phases and rotated coordinates.
         x0_ff <= 14'(madd((MW+1)'(qx0_ff[MS]) + (MW+1)'(phx), w));
         x1_ff <= 14'(madd((MW+1)'(qx1_ff[MS]) + (MW+1)'(phx), w));
         yy_ff <= 14'(madd((MW+1)'(qy_ff[MS]) + (MW+1)'(phy), h));
         cc_ff <= 14'(madd((MW+1)'(qc_ff[MS]) + (MW+1)'(phc), wh));
      end
   end

   uagp_scale u_cu (.clock, .enable(adv), .value(yy_ff), .extent(h), .span(CHROMA_SPAN),
                    .low(CHROMA_LO), .result(cu));
   uagp_scale u_yl (.clock, .enable(adv), .value(x0_ff), .extent(w), .span(LUMA_SPAN),
                    .low(LUMA_LO), .result(yl));
   uagp_scale u_cv (.clock, .enable(adv), .value(cc_ff), .extent(wh), .span(CHROMA_SPAN),
                    .low(CHROMA_LO), .result(cv));
   uagp_scale u_yr (.clock, .enable(adv), .value(x1_ff), .extent(w), .span(LUMA_SPAN),
                    .low(LUMA_LO), .result(yr));

`ifndef ASSERT_OFF
   a_luma: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.luma_left >= LUMA_LO && rsp_data.luma_left <= 8'd235))
      else $error("luma out of range");
   a_chroma: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.chroma_u >= CHROMA_LO && rsp_data.chroma_u <= 8'd192))
      else $error("chroma out of range");
   a_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled beat changed");
`endif

endmodule

// ===== src/uagp_scale.sv =====
module uagp_scale import uagp_pkg::*; (
   input  logic        clock,
   input  logic        enable,
   input  logic [13:0] value,
   input  logic [13:0] extent,
   input  logic [7:0]  span,
   input  logic [7:0]  low,
   output logic [7:0]  result
);
   // Restoring division of value*span by extent-1, eight quotient bits over two
   // pipeline stages of four steps each. The quotient never exceeds span.
   logic [21:0] num_ff;
   logic [13:0] div_ff;
   logic        zero_ff;
   logic [7:0]  low_ff;
   logic [13:0] rem1_ff, div1_ff;
   logic [7:0]  num1_ff, low1_ff;
   logic [3:0]  q1_ff;
   logic        zero1_ff;
   logic [13:0] rem1_in;
   logic [3:0]  q1_in;
   logic [7:0]  q2;
   logic [13:0] rem2;
   logic [14:0] trial1;
   logic [14:0] trial2;
   logic [21:0] prod;

   assign prod = 22'(value) * 22'(span);

   always_ff @(posedge clock) begin
      if (enable) begin
         num_ff <= prod;
         div_ff <= extent - 14'd1;
         zero_ff <= (extent <= 14'd1);
         low_ff <= low;
         rem1_ff <= rem1_in;
         q1_ff <= q1_in;
         num1_ff <= num_ff[7:0];
         div1_ff <= div_ff;
         zero1_ff <= zero_ff;
         low1_ff <= low_ff;
         result <= zero1_ff ? low1_ff : low1_ff + q2;
      end
   end

   always_comb begin
      rem1_in = num_ff[21:8];
      q1_in = '0;
      for (int i = 3; i >= 0; i--) begin
         trial1 = {rem1_in, num_ff[4+i]};
         if (trial1 >= {1'b0, div_ff}) begin
            rem1_in = 14'(trial1 - {1'b0, div_ff});
            q1_in[i] = 1'b1;
         end else begin
            rem1_in = trial1[13:0];
         end
      end
   end

   always_comb begin
      // First stage saw remainder of bits 21:4; finish with bits 3:0.
      rem2 = rem1_ff;
      q2 = {q1_ff, 4'd0};
      for (int i = 3; i >= 0; i--) begin
         trial2 = {rem2, num1_ff[i]};
         if (trial2 >= {1'b0, div1_ff}) begin
            rem2 = 14'(trial2 - {1'b0, div1_ff});
            q2[i] = 1'b1;
         end else begin
            rem2 = trial2[13:0];
         end
      end
   end

endmodule
